// ===== rtl/handle_table_allocator_macros.svh =====
// Assertion macros for the handle table allocator checker.
// Each expects clk and arst_n in scope.
`ifndef HANDLE_TABLE_ALLOCATOR_MACROS_SVH
`define HANDLE_TABLE_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define HAC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hac assertion failed");

// Next-cycle implication.
`define HAC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hac assertion failed");

`endif

// ===== rtl/hac_pkg.sv =====
// ----------------------------------------------------------------------------
// hac_pkg
// Types and constants shared by the handle table allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hac_pkg;

	localparam int HAC_TABLE_SLOTS = 32;
	localparam int HAC_HANDLE_W    = 32;
	localparam int HAC_OBJECT_W    = 16;

	typedef enum logic [2:0] {
		OP_CREATE = 3'd0,
		OP_CLOSE  = 3'd1,
		OP_GET    = 3'd2,
		OP_VALID  = 3'd3,
		OP_CLEAR  = 3'd4
	} hac_op_t;

	typedef struct packed {
		hac_op_t                   opcode;
		logic [HAC_HANDLE_W-1:0]   handle_in;
		logic [HAC_OBJECT_W-1:0]   object_ref;
	} hac_req_t;

	typedef struct packed {
		logic                      ok;
		logic [HAC_HANDLE_W-1:0]   handle_out;
		logic [HAC_OBJECT_W-1:0]   object_out;
		logic                      closed_notice;
		logic                      last;
	} hac_rsp_t;

	typedef struct packed {
		logic                      valid;
		logic [HAC_HANDLE_W-1:0]   handle;
		logic [HAC_OBJECT_W-1:0]   object;
	} hac_entry_t;

	// per-cell controls
	typedef struct packed {
		logic shift;   // take neighbor's entry
		logic wr;      // store new entry
		logic kill;    // drop entry
	} hac_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/hac_cell.sv =====
// ----------------------------------------------------------------------------
// hac_cell
// One table slot: holds an entry, matches it against the broadcast key and
// takes its upper neighbor's entry on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module hac_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  hac_pkg::hac_cell_ctrl_t           ctrl,
	input  hac_pkg::hac_entry_t               nbr,
	input  logic [hac_pkg::HAC_HANDLE_W-1:0]  wr_handle,
	input  logic [hac_pkg::HAC_OBJECT_W-1:0]  wr_object,
	input  logic [hac_pkg::HAC_HANDLE_W-1:0]  key,
	output hac_pkg::hac_entry_t               ent,
	output logic                              match
);
	import hac_pkg::*;

	logic                    valid_q;
	logic [HAC_HANDLE_W-1:0] handle_q;
	logic [HAC_OBJECT_W-1:0] object_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= nbr.valid;
		end else if (ctrl.wr) begin
			valid_q <= 1'b1;
		end else if (ctrl.kill) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			handle_q <= nbr.handle;
			object_q <= nbr.object;
		end else if (ctrl.wr) begin
			handle_q <= wr_handle;
			object_q <= wr_object;
		end
	end

	assign ent   = '{valid: valid_q, handle: handle_q, object: object_q};
	assign match = valid_q && (handle_q == key);

endmodule

`default_nettype wire

// ===== rtl/handle_table_allocator.sv =====
// ----------------------------------------------------------------------------
// handle_table_allocator
// Handle table with a rolling id allocator, built as a row of slot cells.
// ----------------------------------------------------------------------------
// The table is a row of TABLE_SLOTS cells, each holding one (handle, object)
// entry and comparing it against a broadcast key, so a lookup searches all
// cells at once. One request is handled at a time: the request beat is taken
// in the idle state, and req_stall stays high until its last response beat
// has been loaded into the response register. Close, get, is-valid, unknown
// opcodes and a failing create respond from the exec state. A successful
// create probes 1 to TABLE_SLOTS ids in turn, each against all cells at once,
// and the new entry goes to the lowest empty cell. On clear the cells shift
// down toward cell 0 once per cycle while cell 0 is empty or the response is
// free, and cell 0 is reported when it holds an entry, which yields slot
// order and empties the table. A stalled response holds the sequencer where
// it would load the response register. Handle 0 never matches anything.
// ----------------------------------------------------------------------------
`default_nettype none

module handle_table_allocator #(
	parameter int TABLE_SLOTS = hac_pkg::HAC_TABLE_SLOTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  hac_pkg::hac_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output hac_pkg::hac_rsp_t rsp
);
	import hac_pkg::*;

	localparam int CW = $clog2(TABLE_SLOTS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PROBE,
		ST_CLEAR
	} state_t;

	state_t                  state_q;
	hac_op_t                 op_q;
	logic [HAC_HANDLE_W-1:0] handle_q;
	logic [HAC_OBJECT_W-1:0] object_q;
	logic [HAC_HANDLE_W-1:0] next_id_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           clr_cnt_q;
	logic                    rsp_valid_q;
	hac_rsp_t                rsp_q;

	// cell row
	hac_entry_t              ent  [TABLE_SLOTS];
	hac_cell_ctrl_t          ctl  [TABLE_SLOTS];
	logic [TABLE_SLOTS-1:0]  vld;
	logic [TABLE_SLOTS-1:0]  match;
	logic [TABLE_SLOTS-1:0]  low_empty;

	logic [HAC_HANDLE_W-1:0] cand;
	logic [HAC_HANDLE_W-1:0] cand_next;
	logic [HAC_HANDLE_W-1:0] key;
	logic                    hit;
	logic [HAC_OBJECT_W-1:0] hit_obj;
	logic                    out_free;
	logic                    probe_wr;
	logic                    close_kill;
	logic                    clr_shift;
	logic                    clr_done;

	function automatic hac_rsp_t mk_rsp(
		input logic                    ok,
		input logic [HAC_HANDLE_W-1:0] h,
		input logic [HAC_OBJECT_W-1:0] o,
		input logic                    c,
		input logic                    l
	);
		hac_rsp_t r;
		r.ok            = ok;
		r.handle_out    = h;
		r.object_out    = o;
		r.closed_notice = c;
		r.last          = l;
		return r;
	endfunction

	// Candidate id: counter value, skipping 0.
	assign cand      = (next_id_q == '0) ? HAC_HANDLE_W'(1) : next_id_q;
	assign cand_next = cand + HAC_HANDLE_W'(1);
	assign key       = (state_q == ST_PROBE) ? cand : handle_q;

	// Response register frees up this cycle?
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// Lowest empty slot as one-hot.
	assign low_empty = ~vld & (vld + TABLE_SLOTS'(1));

	always_comb begin
		hit_obj = '0;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			hit_obj = hit_obj | (match[i] ? ent[i].object : '0);
		end
	end
	assign hit = |match;

	assign probe_wr   = (state_q == ST_PROBE) && !hit && out_free;
	assign close_kill = (state_q == ST_EXEC) && (op_q == OP_CLOSE) &&
	                    (handle_q != '0) && hit && out_free;
	assign clr_done   = (clr_cnt_q == CW'(TABLE_SLOTS));
	assign clr_shift  = (state_q == ST_CLEAR) && !clr_done &&
	                    (!ent[0].valid || out_free);

	for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
		hac_entry_t nbr;

		if (i == TABLE_SLOTS - 1) begin : g_top
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = ent[i+1];
		end

		assign ctl[i] = '{shift: clr_shift,
		                  wr:    probe_wr && low_empty[i],
		                  kill:  close_kill && match[i]};
		assign vld[i] = ent[i].valid;

		hac_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctl[i]),
			.nbr       (nbr),
			.wr_handle (cand),
			.wr_object (object_q),
			.key       (key),
			.ent       (ent[i]),
			.match     (match[i])
		);
	end

	// Sequencer, bookkeeping and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_CREATE;
			handle_q    <= '0;
			object_q    <= '0;
			next_id_q   <= HAC_HANDLE_W'(1);
			count_q     <= '0;
			clr_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						op_q     <= req.opcode;
						handle_q <= req.handle_in;
						object_q <= req.object_ref;
						state_q  <= ST_EXEC;
					end
				end

				ST_EXEC: begin
					case (op_q)
						OP_CREATE: begin
							if (object_q != '0 && count_q < CW'(TABLE_SLOTS)) begin
								state_q <= ST_PROBE;
							end else if (out_free) begin
								rsp_valid_q <= 1'b1;
								rsp_q       <= mk_rsp(1'b0, '0, '0, 1'b0, 1'b1);
								state_q     <= ST_IDLE;
							end
						end
						OP_CLOSE: begin
							if (out_free) begin
								rsp_valid_q <= 1'b1;
								state_q     <= ST_IDLE;
								if (close_kill) begin
									count_q <= count_q - CW'(1);
									rsp_q   <= mk_rsp(1'b1, '0, hit_obj,
									                  hit_obj != '0, 1'b1);
								end else begin
									rsp_q   <= mk_rsp(1'b0, '0, '0, 1'b0, 1'b1);
								end
							end
						end
						OP_GET: begin
							if (out_free) begin
								rsp_valid_q <= 1'b1;
								state_q     <= ST_IDLE;
								if (hit && handle_q != '0) begin
									rsp_q <= mk_rsp(1'b1, '0, hit_obj, 1'b0, 1'b1);
								end else begin
									rsp_q <= mk_rsp(1'b0, '0, '0, 1'b0, 1'b1);
								end
							end
						end
						OP_VALID: begin
							if (out_free) begin
								rsp_valid_q <= 1'b1;
								state_q     <= ST_IDLE;
								rsp_q       <= mk_rsp(hit && handle_q != '0, '0, '0,
								                      1'b0, 1'b1);
							end
						end
						OP_CLEAR: begin
							clr_cnt_q <= '0;
							state_q   <= ST_CLEAR;
						end
						default: begin
							if (out_free) begin
								rsp_valid_q <= 1'b1;
								state_q     <= ST_IDLE;
								rsp_q       <= mk_rsp(1'b0, '0, '0, 1'b0, 1'b1);
							end
						end
					endcase
				end

				ST_PROBE: begin
					// a used id just advances the counter; a free one is stored
					if (hit) begin
						next_id_q <= cand_next;
					end else if (out_free) begin
						next_id_q   <= cand_next;
						count_q     <= count_q + CW'(1);
						rsp_valid_q <= 1'b1;
						rsp_q       <= mk_rsp(1'b1, cand, '0, 1'b0, 1'b1);
						state_q     <= ST_IDLE;
					end
				end

				ST_CLEAR: begin
					if (clr_done) begin
						if (out_free) begin
							count_q     <= '0;
							rsp_valid_q <= 1'b1;
							rsp_q       <= mk_rsp(1'b1, '0, '0, 1'b0, 1'b1);
							state_q     <= ST_IDLE;
						end
					end else if (clr_shift) begin
						clr_cnt_q <= clr_cnt_q + CW'(1);
						if (ent[0].valid) begin
							rsp_valid_q <= 1'b1;
							rsp_q       <= mk_rsp(1'b1, ent[0].handle, ent[0].object,
							                      ent[0].object != '0, 1'b0);
						end
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/hac_checker.sv =====
// ----------------------------------------------------------------------------
// hac_checker
// Port-level checks for the handle table allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "handle_table_allocator_macros.svh"

module hac_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input hac_pkg::hac_rsp_t rsp
);
	import hac_pkg::*;

	// stalled response beat holds
	`HAC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// one request at a time: stall rises right after a request beat
	`HAC_ASSERT_NEXT(a_one_req, req_valid && !req_stall, req_stall)

	// only clear emits non-final beats, and those are successes
	`HAC_ASSERT_NOW(a_mid_ok, rsp_valid && !rsp.last, rsp.ok)

	// failures carry nothing but last
	`HAC_ASSERT_NOW(a_fail_zero, rsp_valid && !rsp.ok,
		rsp.handle_out == '0 && rsp.object_out == '0 && !rsp.closed_notice && rsp.last)

	// closed notice names a real object
	`HAC_ASSERT_NOW(a_notice_obj, rsp_valid && rsp.closed_notice, rsp.object_out != '0)

endmodule

bind handle_table_allocator hac_checker u_hac_checker (.*);

`default_nettype wire
